// ===== rtl/mhpq_pkg.sv =====
// shared types and constants for the min-heap priority queue
package mhpq_pkg;

  localparam int CAPACITY_DEF = 256;
  localparam int KEY_W        = 32;
  localparam int TAG_W        = 9;
  localparam int FILL_W       = 9;

  typedef enum logic {
    FN_INSERT = 1'b0,
    FN_REMOVE = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic    ins_start;
    logic    rm_start;
    logic    up_read;
    logic    up_step;
    logic    rm_read;
    logic    rm_take;
    logic    dn_read;
    logic    dn_step;
    logic    place;
    logic    emit;
    status_t code;
  } mhpq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic at_root;
    logic up_move;
    logic dn_move;
  } mhpq_stat_t;

endpackage

// ===== rtl/min_heap_priority_queue_unit.sv =====
// Binary min-heap priority queue of key/tag entries. Pulse start while busy is
// low with func 0 to insert (entry_key, entry_tag) or func 1 to remove the
// minimum. Exactly one result comes back per beat, valid for the single cycle
// in which done is high; it cannot be held off. A rejected insert (full) or
// remove (empty) answers in the next cycle and never raises busy. An insert
// climbs from the hole one level at a time until it reaches the root or meets a
// parent whose key is not larger; a remove takes the root, moves the last entry
// there and sifts it down until no child is smaller. The result beat comes in
// the first cycle in which busy is low again. Each level takes a registered
// read of the two-read-port heap store followed by a compare/write step. The
// heap keeps no clearing pass: entries at or above the fill count are never
// used. A moving entry never swaps with an entry of equal key.
module min_heap_priority_queue_unit
  import mhpq_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic              func,
  input  logic [KEY_W-1:0]  entry_key,
  input  logic [TAG_W-1:0]  entry_tag,
  output logic              done,
  output logic [1:0]        status,
  output logic [KEY_W-1:0]  min_key,
  output logic [TAG_W-1:0]  min_tag,
  output logic [FILL_W-1:0] fill_count
);

  mhpq_cmd_t  cmd;
  mhpq_stat_t st;

  mhpq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .func  (func),
    .st    (st),
    .busy  (busy),
    .cmd   (cmd)
  );

  mhpq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .entry_key  (entry_key),
    .entry_tag  (entry_tag),
    .cmd        (cmd),
    .st         (st),
    .done       (done),
    .status     (status),
    .min_key    (min_key),
    .min_tag    (min_tag),
    .fill_count (fill_count)
  );

endmodule

// ===== rtl/mhpq_ctrl.sv =====
// sequencing state machine for insert / sift-up and remove / sift-down
module mhpq_ctrl
  import mhpq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       func,
  input  mhpq_stat_t st,
  output logic       busy,
  output mhpq_cmd_t  cmd
);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_UP_RD   = 7'b0000010,
    S_UP_CMP  = 7'b0000100,
    S_RM_RD   = 7'b0001000,
    S_RM_TAKE = 7'b0010000,
    S_DN_RD   = 7'b0100000,
    S_DN_CMP  = 7'b1000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.code   = ST_OK;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          if (func_t'(func) == FN_INSERT) begin
            if (st.full) begin
              cmd.emit = 1'b1;
              cmd.code = ST_FULL;
            end else begin
              cmd.ins_start = 1'b1;
              state_next    = S_UP_RD;
            end
          end else begin
            if (st.empty) begin
              cmd.emit = 1'b1;
              cmd.code = ST_EMPTY;
            end else begin
              cmd.rm_start = 1'b1;
              state_next   = S_RM_RD;
            end
          end
        end
      end
      S_UP_RD: begin
        if (st.at_root) begin
          cmd.place  = 1'b1;
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.up_read = 1'b1;
          state_next  = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (st.up_move) begin
          cmd.up_step = 1'b1;
          state_next  = S_UP_RD;
        end else begin
          cmd.place  = 1'b1;
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_RM_RD: begin
        cmd.rm_read = 1'b1;
        state_next  = S_RM_TAKE;
      end
      S_RM_TAKE: begin
        cmd.rm_take = 1'b1;
        state_next  = S_DN_RD;
      end
      S_DN_RD: begin
        cmd.dn_read = 1'b1;
        state_next  = S_DN_CMP;
      end
      S_DN_CMP: begin
        if (st.dn_move) begin
          cmd.dn_step = 1'b1;
          state_next  = S_DN_RD;
        end else begin
          cmd.place  = 1'b1;
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/mhpq_datapath.sv =====
// heap store, hole position, moving entry, compare logic and result registers
module mhpq_datapath
  import mhpq_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [KEY_W-1:0]  entry_key,
  input  logic [TAG_W-1:0]  entry_tag,
  input  mhpq_cmd_t         cmd,
  output mhpq_stat_t        st,
  output logic              done,
  output logic [1:0]        status,
  output logic [KEY_W-1:0]  min_key,
  output logic [TAG_W-1:0]  min_tag,
  output logic [FILL_W-1:0] fill_count
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CW    = IDX_W + 2;

  entry_t mem [CAPACITY];

  logic [CNT_W-1:0]        count;
  logic [IDX_W-1:0]        pos;
  logic [IDX_W-1:0]        pos_m1;
  logic [IDX_W-1:0]        par;
  entry_t                  hold;
  entry_t                  rda;
  entry_t                  rdb;
  entry_t                  wdata;
  logic                    we;
  logic [IDX_W-1:0]        ra;
  logic [IDX_W-1:0]        rb;
  logic [CW-1:0]           lidx;
  logic [CW-1:0]           ridx;
  logic [CW-1:0]           cnt_w;
  logic                    take_l;
  logic                    take_r;
  logic [KEY_W-1:0]        bkey;
  logic [KEY_W-1:0]        mk;
  logic [TAG_W-1:0]        mt;
  logic [CNT_W+FILL_W-1:0] cnt_ext;

  assign pos_m1  = pos - IDX_W'(1);
  assign par     = pos_m1 >> 1;
  assign lidx    = {1'b0, pos, 1'b1};
  assign ridx    = lidx + CW'(1);
  assign cnt_w   = CW'(count);
  assign cnt_ext = {{FILL_W{1'b0}}, count};

  // smallest of hole entry, left and right; left tested first, strict less-than
  assign take_l = (lidx < cnt_w) && (rda.key < hold.key);
  assign bkey   = take_l ? rda.key : hold.key;
  assign take_r = (ridx < cnt_w) && (rdb.key < bkey);

  assign st.full    = (count == CNT_W'(CAPACITY));
  assign st.empty   = (count == '0);
  assign st.at_root = (pos == '0);
  assign st.up_move = (hold.key < rda.key);
  assign st.dn_move = take_l | take_r;

  assign ra = cmd.up_read ? par : (cmd.dn_read ? lidx[IDX_W-1:0] : '0);
  assign rb = cmd.dn_read ? ridx[IDX_W-1:0] : count[IDX_W-1:0];

  assign we = cmd.place | cmd.up_step | cmd.dn_step;

  always_comb begin
    priority if (cmd.place) begin
      wdata = hold;
    end else if (cmd.up_step) begin
      wdata = rda;
    end else begin
      wdata = take_r ? rdb : rda;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[pos] <= wdata;
    end
    rda <= mem[ra];
    rdb <= mem[rb];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= cmd.emit;
      if (cmd.ins_start) begin
        count <= count + CNT_W'(1);
      end else if (cmd.rm_start) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ins_start) begin
      hold <= {entry_key, entry_tag};
      pos  <= count[IDX_W-1:0];
      mk   <= '0;
      mt   <= '0;
    end
    if (cmd.up_step) begin
      pos <= par;
    end
    if (cmd.rm_take) begin
      mk   <= rda.key;
      mt   <= rda.tag;
      hold <= rdb;
      pos  <= '0;
    end
    if (cmd.dn_step) begin
      pos <= take_r ? ridx[IDX_W-1:0] : lidx[IDX_W-1:0];
    end
    if (cmd.emit) begin
      status     <= cmd.code;
      fill_count <= cnt_ext[FILL_W-1:0];
      if (cmd.code == ST_OK) begin
        min_key <= mk;
        min_tag <= mt;
      end else begin
        min_key <= '0;
        min_tag <= '0;
      end
    end
  end

endmodule

// ===== rtl/mhpq_checker.sv =====
// port-level checks for the min-heap priority queue, bound to the top level
module mhpq_checker
  import mhpq_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input logic [1:0]        status,
  input logic [KEY_W-1:0]  min_key,
  input logic [TAG_W-1:0]  min_tag,
  input logic [FILL_W-1:0] fill_count
);

  localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(CAPACITY);

  // failed beats carry no entry
  a_fail_zero : assert property (@(posedge clk) disable iff (rst)
    done && (status != ST_OK) |-> (min_key == '0) && (min_tag == '0))
    else $error("failed beat carries nonzero entry");

  a_full_fill : assert property (@(posedge clk) disable iff (rst)
    done && (status == ST_FULL) |-> fill_count == FULL_FILL)
    else $error("full status with fill count below capacity");

  a_empty_fill : assert property (@(posedge clk) disable iff (rst)
    done && (status == ST_EMPTY) |-> fill_count == '0)
    else $error("empty status with nonzero fill count");

  // a multi-cycle operation always ends in a result beat
  a_end_done : assert property (@(posedge clk) disable iff (rst)
    $fell(busy) && !$past(rst) |-> done)
    else $error("busy dropped without a result");

  a_busy_start : assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a start");

endmodule

bind min_heap_priority_queue_unit mhpq_checker #(.CAPACITY(CAPACITY)) u_mhpq_checker (.*);
